/* rtl/core/shortest_seek_first_scheduler_top_assert.svh */
// Assertion macros for the shortest-seek-first scheduler.
`ifndef SHORTEST_SEEK_FIRST_SCHEDULER_TOP_ASSERT_SVH
`define SHORTEST_SEEK_FIRST_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ssf_pkg.sv */
// Package: sizes, constants and beat types of the shortest-seek-first scheduler.
package ssf_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TRACK_BITS  = 12;

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = 18;
    localparam int SUM_MAX = 262143;
    localparam int DIST_MAX = 4095;

    typedef struct packed {
        logic [11:0] track;
        logic [3:0]  prio;
        logic        last_request;
    } t_req;

    typedef struct packed {
        logic [5:0]  served_index;
        logic [11:0] served_track;
        logic [11:0] seek_distance;
        logic [17:0] total_movement;
        logic        last_served;
    } t_res;

endpackage

/* rtl/core/shortest_seek_first_scheduler_top.sv */
// Throughput: request beats load one per cycle while in the load state; the closing beat
// starts the serving pass. Each result takes a sweep of the n stored requests through the
// memory read port and a single distance/priority comparator, then one drain and one pick.
// The first result is registered when the first pick goes, which waits while the output stalls.
// Reset (synchronous, active low) empties the queue, clears served flags and start_head.
// Queue memory contents are not cleared; only entries below the fill count are read.
module shortest_seek_first_scheduler_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ssf_pkg::t_req        i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ssf_pkg::t_res        o_out,
    input  logic                 i_cfg_we,
    input  logic [11:0]          i_cfg_wdata
);

    localparam int TB = ssf_pkg::TRACK_BITS;
    localparam int IW = ssf_pkg::IDX_W;
    localparam int CW = ssf_pkg::CNT_W;
    localparam int SW = ssf_pkg::SUM_W;

    // Sequencer: load requests, sweep the queue, drain the last compare, pick the winner.
    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_PICK  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Request queue memory (no reset; fill count guards reads)
    logic [TB-1:0] r_trk_mem  [ssf_pkg::QUEUE_DEPTH];
    logic [3:0]    r_prio_mem [ssf_pkg::QUEUE_DEPTH];

    logic [11:0]   r_start_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_done, n_done;
    logic [ssf_pkg::QUEUE_DEPTH-1:0] r_flags, n_flags;
    logic [TB-1:0] r_head, n_head;
    logic [SW-1:0] r_sum, n_sum;

    // Sweep: read address, registered read data, compare-stage tag
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [TB-1:0] r_rd_trk;
    logic [3:0]    r_rd_prio;
    logic          r_cmp_vld, n_cmp_vld;
    logic [IW-1:0] r_cmp_idx;

    // Running best
    logic          r_found, n_found;
    logic [IW-1:0] r_best_idx, n_best_idx;
    logic [TB-1:0] r_best_dist, n_best_dist;
    logic [TB-1:0] r_best_trk, n_best_trk;
    logic [3:0]    r_best_prio, n_best_prio;

    // Output register
    logic          r_out_vld, n_out_vld;
    ssf_pkg::t_res r_out, n_out;

    logic          in_acc;
    logic          wr_en;
    logic          rd_en;
    logic [TB-1:0] cur_dist;
    logic          take;
    logic          pick_go;
    logic          pick_last;
    logic [SW:0]   sum_ext;

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign in_acc  = i_in_valid && (r_state == S_LOAD);
    // Beats past the queue depth are dropped; a closing one still closes the batch.
    assign wr_en   = in_acc && (r_count < CW'(ssf_pkg::QUEUE_DEPTH));
    assign rd_en   = (r_state == S_SCAN);

    // Comparator: one distance against the running best each cycle
    assign cur_dist = (r_rd_trk > r_head) ? (r_rd_trk - r_head) : (r_head - r_rd_trk);
    assign take = r_cmp_vld && !r_flags[r_cmp_idx] &&
                  (!r_found || (cur_dist < r_best_dist) ||
                   ((cur_dist == r_best_dist) && (r_rd_prio > r_best_prio)));

    assign pick_go   = !r_out_vld || !i_out_stall;
    assign pick_last = (r_done == (r_count - CW'(1)));
    assign sum_ext   = (SW+1)'(r_sum) + (SW+1)'(r_best_dist);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_done      = r_done;
        n_flags     = r_flags;
        n_head      = r_head;
        n_sum       = r_sum;
        n_rd_idx    = r_rd_idx;
        n_cmp_vld   = rd_en;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        n_best_trk  = r_best_trk;
        n_best_prio = r_best_prio;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out       = r_out;

        if (take) begin
            n_found     = 1'b1;
            n_best_idx  = r_cmp_idx;
            n_best_dist = cur_dist;
            n_best_trk  = r_rd_trk;
            n_best_prio = r_rd_prio;
        end

        unique case (r_state)
            S_LOAD: begin
                if (wr_en) begin
                    n_count = r_count + CW'(1);
                end
                if (in_acc && i_in.last_request) begin
                    n_head   = TB'(r_start_head);
                    n_sum    = '0;
                    n_done   = '0;
                    n_rd_idx = '0;
                    n_found  = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_idx == IW'(n_count - CW'(1))) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + IW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                if (pick_go) begin
                    n_out_vld = 1'b1;
                    n_flags[r_best_idx] = 1'b1;
                    n_head = r_best_trk;
                    n_sum  = (sum_ext > (SW+1)'(ssf_pkg::SUM_MAX)) ?
                             SW'(ssf_pkg::SUM_MAX) : SW'(sum_ext);
                    n_out.served_index   = 6'(r_best_idx);
                    n_out.served_track   = 12'(r_best_trk);
                    n_out.seek_distance  = (32'(r_best_dist) > ssf_pkg::DIST_MAX) ?
                                           12'(ssf_pkg::DIST_MAX) : 12'(r_best_dist);
                    n_out.total_movement = n_sum;
                    n_out.last_served    = pick_last;
                    if (pick_last) begin
                        // batch over: back to an empty queue
                        n_flags = '0;
                        n_count = '0;
                        n_sum   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_done   = r_done + CW'(1);
                        n_rd_idx = '0;
                        n_found  = 1'b0;
                        n_state  = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_start_head <= '0;
            r_count      <= '0;
            r_done       <= '0;
            r_flags      <= '0;
            r_sum        <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_start_head <= i_cfg_wdata;
            end
            r_count   <= n_count;
            r_done    <= n_done;
            r_flags   <= n_flags;
            r_sum     <= n_sum;
            r_cmp_vld <= n_cmp_vld;
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_head      <= n_head;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= r_rd_idx;
        r_best_idx  <= n_best_idx;
        r_best_dist <= n_best_dist;
        r_best_trk  <= n_best_trk;
        r_best_prio <= n_best_prio;
        r_out       <= n_out;
    end

    // Queue memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_trk_mem[r_count[IW-1:0]]  <= TB'(i_in.track);
            r_prio_mem[r_count[IW-1:0]] <= i_in.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_trk  <= r_trk_mem[r_rd_idx];
        r_rd_prio <= r_prio_mem[r_rd_idx];
    end

`include "shortest_seek_first_scheduler_top_assert.svh"

    // The comparator only ever sees entries that were written in this batch.
    `SSF_ASSERT_NOW(a_cmp_in_range, r_cmp_vld, 32'(r_cmp_idx) < 32'(r_count), "compare past fill")
    // A pick always has a winner that has not been served yet.
    `SSF_ASSERT_NOW(a_pick_fresh, r_state == S_PICK, r_found && !r_flags[r_best_idx], "bad pick")
    // Never more served flags than stored requests.
    `SSF_ASSERT_NOW(a_flags_bound, 1'b1, 32'($countones(r_flags)) <= 32'(r_count), "flag overrun")
    // A closing beat leaves the load state and blocks further beats.
    `SSF_ASSERT_NEXT(a_close_scan, in_acc && i_in.last_request, r_state == S_SCAN, "no scan")

endmodule
